// ===== rtl/core/scfd_pkg.sv =====
// ----------------------------------------------------------------------------
// scfd_pkg
// shared types and constants of the serial command frame detector
// ----------------------------------------------------------------------------
package scfd_pkg;

  localparam int unsigned WIN_DEPTH  = 8;
  localparam int unsigned FILL_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [7:0] HDR_MASK  = 8'hF8;
  localparam logic [7:0] SYNC_BYTE = 8'hFF;

  // frame lengths per mode
  localparam logic [FILL_W-1:0] LEN_CHECKSUM = 4'd4;
  localparam logic [FILL_W-1:0] LEN_INVERT   = 4'd8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BITS = 2'd1;

  // item opcodes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // frame modes
  localparam logic MODE_CHECKSUM = 1'b0;
  localparam logic MODE_INVERT   = 1'b1;

  typedef logic [WIN_DEPTH-1:0][7:0] window_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] cmd;
    logic [7:0] ident;
    logic [7:0] value;
  } check_t;

endpackage

// ===== rtl/core/scfd_cell.sv =====
// ----------------------------------------------------------------------------
// scfd_cell
// one byte stage of the window shift chain
// ----------------------------------------------------------------------------
module scfd_cell (
  input  logic       clk_i,
  input  logic       shift_i,
  input  logic [7:0] byte_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_q;

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;

endmodule

// ===== rtl/core/scfd_check.sv =====
// ----------------------------------------------------------------------------
// scfd_check
// frame check over the window as it stands after the newest byte
// ----------------------------------------------------------------------------
module scfd_check (
  input  scfd_pkg::window_t win_i,       // entry 0 is the newest byte
  input  logic              frame_mode_i,
  input  logic [4:0]        header_bits_i,
  output scfd_pkg::check_t  check_o
);

  import scfd_pkg::*;

  logic ok_sum;
  logic ok_inv;

  always_comb begin
    ok_sum = ((win_i[3] & HDR_MASK) == {header_bits_i, 3'b000}) &&
             ((win_i[3] ^ win_i[2] ^ win_i[1] ^ win_i[0]) == 8'h00);
    ok_inv = (win_i[7] == SYNC_BYTE) && (win_i[6] == SYNC_BYTE) &&
             (win_i[4] == ~win_i[5]) && (win_i[2] == ~win_i[3]) &&
             (win_i[0] == ~win_i[1]);
    unique case (frame_mode_i)
      MODE_INVERT: begin
        check_o.ok    = ok_inv;
        check_o.cmd   = win_i[5];
        check_o.ident = win_i[3];
        check_o.value = win_i[1];
      end
      default: begin
        check_o.ok    = ok_sum;
        check_o.cmd   = win_i[3];
        check_o.ident = win_i[2];
        check_o.value = win_i[1];
      end
    endcase
  end

endmodule

// ===== rtl/core/serial_command_frame_detector.sv =====
// ----------------------------------------------------------------------------
// serial_command_frame_detector
// sliding-window command frame sync for received uart bytes
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o) carries one beat per item: a
//   received byte with its line error flag, or a clear of the window.
//   bytes with a line error are dropped. each good byte shifts into a chain
//   of eight byte cells; once enough bytes are held the newest frame is
//   checked (four-byte xor checksum or eight-byte inverted-copy frame).
//   a good frame gives one beat on the output channel (out_valid_o /
//   out_stall_i) with command, id and value, and empties the window.
//   throughput: one item per cycle while in_stall_o is low.
//   each result is registered in the output register, or in the skid register.
//   when the receiver stalls, one more result fits in a skid register; only
//   with both output and skid full does in_stall_o rise.
//   configuration writes (cfg_valid_i / cfg_ready_o) are always taken and
//   must only happen while the block is idle.
//   reset: window empty, no result pending, frame_mode and header_bits zero.
// ----------------------------------------------------------------------------
module serial_command_frame_detector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [scfd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic [7:0]                      rx_byte_i,
  input  logic                            line_error_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      command_byte_o,
  output logic [7:0]                      ident_byte_o,
  output logic [7:0]                      value_byte_o
);

  import scfd_pkg::*;

  // configuration registers
  logic       frame_mode_q;
  logic [4:0] header_bits_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_mode_q  <= MODE_CHECKSUM;
      header_bits_q <= 5'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_FRAME_MODE:  frame_mode_q  <= cfg_data_i[0];
        REG_HEADER_BITS: header_bits_q <= cfg_data_i[4:0];
        default: ;  // writes beyond the register list are ignored
      endcase
    end
  end

  // input beat decode
  logic in_take;
  logic byte_push;

  assign in_take   = in_valid_i && !in_stall_o;
  assign byte_push = in_take && (op_i == OP_BYTE) && !line_error_i;

  // byte cell chain, cell 0 holds the newest byte
  logic [7:0] cell_q [WIN_DEPTH];
  window_t    win_next;

  for (genvar g = 0; g < WIN_DEPTH; g++) begin : g_cell
    logic [7:0] cell_in;
    if (g == 0) begin : g_head
      assign cell_in = rx_byte_i;
    end else begin : g_tail
      assign cell_in = cell_q[g-1];
    end
    scfd_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (byte_push),
      .byte_i  (cell_in),
      .byte_o  (cell_q[g])
    );
    // window as it will be after this byte shifts in
    assign win_next[g] = cell_in;
  end

  // frame check on the shifted window
  check_t check;

  scfd_check u_check (
    .win_i         (win_next),
    .frame_mode_i  (frame_mode_q),
    .header_bits_i (header_bits_q),
    .check_o       (check)
  );

  // fill count
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] fill_inc;
  logic [FILL_W-1:0] frame_len;
  logic              frame_full;
  logic              emit;

  always_comb begin
    fill_inc   = (fill_q == FILL_W'(WIN_DEPTH)) ? fill_q : fill_q + 1'b1;
    frame_len  = (frame_mode_q == MODE_INVERT) ? LEN_INVERT : LEN_CHECKSUM;
    frame_full = (fill_inc >= frame_len);
    emit       = byte_push && frame_full && check.ok;
    fill_d     = fill_q;
    priority if (in_take && (op_i == OP_CLEAR)) begin
      fill_d = '0;
    end else if (byte_push && frame_full) begin
      // good frame empties, bad frame drops its oldest byte and older
      fill_d = check.ok ? '0 : frame_len - 1'b1;
    end else if (byte_push) begin
      fill_d = fill_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // output register with one skid entry
  logic       out_valid_q;
  logic       skid_valid_q;
  logic [7:0] out_cmd_q, out_id_q, out_val_q;
  logic [7:0] skid_cmd_q, skid_id_q, skid_val_q;
  logic       out_take;

  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      // input is stalled here, only drain the skid
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (emit) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_cmd_q <= skid_cmd_q;
        out_id_q  <= skid_id_q;
        out_val_q <= skid_val_q;
      end
    end else if (emit) begin
      if (out_valid_q && !out_take) begin
        skid_cmd_q <= check.cmd;
        skid_id_q  <= check.ident;
        skid_val_q <= check.value;
      end else begin
        out_cmd_q <= check.cmd;
        out_id_q  <= check.ident;
        out_val_q <= check.value;
      end
    end
  end

  assign in_stall_o     = skid_valid_q;
  assign out_valid_o    = out_valid_q;
  assign command_byte_o = out_cmd_q;
  assign ident_byte_o   = out_id_q;
  assign value_byte_o   = out_val_q;

endmodule

// ===== rtl/core/scfd_assert.sv =====
// ----------------------------------------------------------------------------
// scfd_assert
// port-level checks of the serial command frame detector
// ----------------------------------------------------------------------------
module scfd_assert (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       op_i,
  input logic       line_error_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] command_byte_o,
  input logic [7:0] ident_byte_o,
  input logic [7:0] value_byte_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(command_byte_o) &&
    $stable(ident_byte_o) && $stable(value_byte_o))
    else $error("stalled result changed");

  // a new result only follows a good byte beat
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && !op_i && !line_error_i))
    else $error("result without a byte beat");

  // input stalls only with a result pending
  a_stall_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // input stall rises only after the receiver held off a result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without receiver stall");

endmodule

bind serial_command_frame_detector scfd_assert u_scfd_assert (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .op_i           (op_i),
  .line_error_i   (line_error_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .command_byte_o (command_byte_o),
  .ident_byte_o   (ident_byte_o),
  .value_byte_o   (value_byte_o)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the serial command frame detector
// ----------------------------------------------------------------------------
// directed tests cover both frame formats, line errors, clears, a window that
// slides past a bad check, a mode switch over a longer window and register
// masking. random phases then run mostly well-formed frames with random
// content, mixed with broken frames, noise bytes and clears, under a range of
// register settings. a shadow of the sync window predicts every frame. each
// output beat is compared with the oldest prediction. the sender runs in
// bursts, the receiver stalls on its own pattern, and one test holds the
// output off long enough to fill the block and stall its input.
// ----------------------------------------------------------------------------
module tb_top;
  import scfd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned PHASE_ITEMS    = 65;
  localparam int unsigned RANDOM_PHASES  = 10;
  // index past the two registers, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] ident;
    logic [7:0] value;
  } frame_t;

  // dut connections, all inputs known from time zero
  logic                  clk         = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  op          = OP_BYTE;
  logic [7:0]            rx_byte     = '0;
  logic                  line_error  = 1'b0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [7:0]            command_byte;
  logic [7:0]            ident_byte;
  logic [7:0]            value_byte;

  // shadow of the sync window and of the registers
  logic [7:0]        win_bytes [WIN_DEPTH];
  logic [FILL_W-1:0] win_fill      = '0;
  logic              mode_shadow   = MODE_CHECKSUM;
  logic [4:0]        header_shadow = '0;

  // frames predicted but not yet seen on the output
  frame_t expected_frames [$];

  int unsigned fail_count     = 0;
  int unsigned items_sent     = 0;
  int unsigned burst_left     = 0;
  int unsigned idle_cycles    = 0;
  int unsigned stall_pct      = 0;
  int unsigned stall_seg_left = 0;
  bit          hold_req       = 1'b0;

  serial_command_frame_detector DUT (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op),
    .rx_byte_i      (rx_byte),
    .line_error_i   (line_error),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .command_byte_o (command_byte),
    .ident_byte_o   (ident_byte),
    .value_byte_o   (value_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // window predictor: one accepted item in, at most one frame queued
  // --------------------------------------------------------------------------
  function automatic void track_window(input logic item_op, input logic [7:0] item_byte,
                                       input logic item_err);
    logic [FILL_W-1:0] frame_len;
    logic              good;
    frame_t            f;
    int                i;
    if (item_op == OP_CLEAR) begin
      win_fill = '0;
      return;
    end
    // bytes with a line error leave the window untouched
    if (item_err) return;
    for (i = WIN_DEPTH - 1; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = item_byte;
    if (win_fill < WIN_DEPTH) win_fill++;
    frame_len = (mode_shadow == MODE_INVERT) ? LEN_INVERT : LEN_CHECKSUM;
    if (win_fill < frame_len) return;
    // newest frame_len bytes form the candidate, entry 0 newest
    if (mode_shadow == MODE_CHECKSUM) begin
      f.cmd   = win_bytes[3];
      f.ident = win_bytes[2];
      f.value = win_bytes[1];
      good = ((win_bytes[3] & HDR_MASK) == {header_shadow, 3'b000}) &&
             ((win_bytes[3] ^ win_bytes[2] ^ win_bytes[1] ^ win_bytes[0]) == 8'h00);
    end else begin
      f.cmd   = win_bytes[5];
      f.ident = win_bytes[3];
      f.value = win_bytes[1];
      good = (win_bytes[7] == SYNC_BYTE) && (win_bytes[6] == SYNC_BYTE) &&
             (win_bytes[4] == ~win_bytes[5]) && (win_bytes[2] == ~win_bytes[3]) &&
             (win_bytes[0] == ~win_bytes[1]);
    end
    // a bad check drops the oldest byte of the frame and anything older
    if (!good) begin
      win_fill = frame_len - 1'b1;
    end else begin
      win_fill = '0;
      expected_frames.push_back(f);
    end
  endfunction

  // --------------------------------------------------------------------------
  // result checker: every output beat against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_frames
    frame_t exp_f;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected frame: command_byte %02h ident_byte %02h value_byte %02h",
               command_byte, ident_byte, value_byte);
        fail_count++;
      end else begin
        exp_f = expected_frames.pop_front();
        if (command_byte !== exp_f.cmd) begin
          $error("command_byte: expected %02h, actual %02h", exp_f.cmd, command_byte);
          fail_count++;
        end
        if (ident_byte !== exp_f.ident) begin
          $error("ident_byte: expected %02h, actual %02h", exp_f.ident, ident_byte);
          fail_count++;
        end
        if (value_byte !== exp_f.value) begin
          $error("value_byte: expected %02h, actual %02h", exp_f.value, value_byte);
          fail_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver stall pattern: segments of random length and stall density,
  // density zero gives stretches with no stall at all; a hold request
  // keeps the output stalled for a long fixed stretch
  // --------------------------------------------------------------------------
  always begin
    @(posedge clk);
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_req = 1'b0;
    end else begin
      if (stall_seg_left == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
        stall_seg_left = $urandom_range(5, 60);
      end
      stall_seg_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // watchdog: ends the run after too many cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // shared drivers
  // --------------------------------------------------------------------------

  // one input beat; between bursts valid may drop for a random gap
  task automatic send_item(input logic item_op, input logic [7:0] item_byte,
                           input logic item_err);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    op         <= item_op;
    rx_byte    <= item_byte;
    line_error <= item_err;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
    track_window(item_op, item_byte, item_err);
  endtask

  // register write, only called while the block is idle
  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_FRAME_MODE)
      mode_shadow = data[0];
    else if (idx == REG_HEADER_BITS)
      header_shadow = data[4:0];
  endtask

  // stop sending and wait until every predicted frame has come out,
  // then let any check that produces no frame settle
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one frame of the current mode with random content, optionally with one
  // flipped bit; now and then a dropped byte with a line error slips in
  task automatic send_command_frame(input bit corrupt);
    logic [7:0]  seq [8];
    logic [7:0]  c, d, v;
    int unsigned len;
    int unsigned k;
    c = 8'($urandom);
    d = 8'($urandom);
    v = 8'($urandom);
    if (mode_shadow == MODE_CHECKSUM) begin
      // mostly the right header, sometimes a random one
      if ($urandom_range(0, 9) != 0) c[7:3] = header_shadow;
      seq[0] = c;
      seq[1] = d;
      seq[2] = v;
      seq[3] = c ^ d ^ v;
      len = LEN_CHECKSUM;
    end else begin
      seq = '{SYNC_BYTE, SYNC_BYTE, c, ~c, d, ~d, v, ~v};
      len = LEN_INVERT;
    end
    if (corrupt) begin
      k = $urandom_range(0, len - 1);
      seq[k] = seq[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < 6) send_item(OP_BYTE, 8'($urandom), 1'b1);
      send_item(OP_BYTE, seq[k], 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset settings: checksum mode, header zero; a clear drops a stray byte
  // and a byte with a line error inside the frame is skipped
  task automatic test_checksum_defaults();
    send_item(OP_BYTE, 8'hFF, 1'b0);
    send_item(OP_CLEAR, 8'hA5, 1'b1);
    send_item(OP_BYTE, 8'h03, 1'b0);
    send_item(OP_BYTE, 8'hAA, 1'b1);
    send_item(OP_BYTE, 8'h10, 1'b0);
    send_item(OP_BYTE, 8'h20, 1'b0);
    send_item(OP_BYTE, 8'h33, 1'b0);
    wait_for_idle();
  endtask

  // invert frame behind one extra sync byte: the first full window fails,
  // drops its oldest byte and the next byte completes a good frame
  task automatic test_invert_frame();
    set_register(REG_FRAME_MODE, 8'h01);
    set_register(REG_SPARE, 8'hFF);
    send_item(OP_BYTE, 8'hFF, 1'b0);
    send_item(OP_BYTE, 8'hFF, 1'b0);
    send_item(OP_BYTE, 8'hFF, 1'b0);
    send_item(OP_BYTE, 8'h00, 1'b0);
    send_item(OP_BYTE, 8'hFF, 1'b0);
    send_item(OP_BYTE, 8'h80, 1'b0);
    send_item(OP_BYTE, 8'h7F, 1'b0);
    send_item(OP_BYTE, 8'hFF, 1'b0);
    send_item(OP_BYTE, 8'h00, 1'b0);
    wait_for_idle();
  endtask

  // seven bytes left in an invert window, then checksum mode: only the
  // newest four bytes are checked; upper data bits of both writes ignored
  task automatic test_mode_switch_window();
    send_item(OP_BYTE, 8'hFF, 1'b0);
    send_item(OP_BYTE, 8'hFF, 1'b0);
    send_item(OP_BYTE, 8'h5A, 1'b0);
    send_item(OP_BYTE, 8'hA5, 1'b0);
    send_item(OP_BYTE, 8'h3C, 1'b0);
    send_item(OP_BYTE, 8'hC3, 1'b0);
    send_item(OP_BYTE, 8'h78, 1'b0);
    wait_for_idle();
    set_register(REG_HEADER_BITS, 8'hE7);
    set_register(REG_FRAME_MODE, 8'hFE);
    send_item(OP_BYTE, 8'h87, 1'b0);
    wait_for_idle();
  endtask

  // long output hold while good frames keep coming: output and skid fill,
  // then the input stalls until the hold ends
  task automatic test_output_backpressure();
    set_register(REG_FRAME_MODE, {7'b0, MODE_CHECKSUM});
    set_register(REG_HEADER_BITS, 8'($urandom));
    hold_req = 1'b1;
    repeat (8) send_command_frame(1'b0);
    wait_for_idle();
  endtask

  // random phases, each with its own settings, extremes first
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    logic        want_mode;
    logic [4:0]  want_hdr;
    logic [7:0]  data;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          want_mode = MODE_CHECKSUM;
          want_hdr  = 5'd31;
        end
        1: begin
          want_mode = MODE_INVERT;
          want_hdr  = 5'd0;
        end
        2: begin
          want_mode = MODE_CHECKSUM;
          want_hdr  = 5'd0;
        end
        3: begin
          want_mode = MODE_INVERT;
          want_hdr  = 5'd31;
        end
        default: begin
          want_mode = 1'($urandom);
          want_hdr  = 5'($urandom);
        end
      endcase
      wait_for_idle();
      // random upper bits in the data must not matter
      data = 8'($urandom);
      data[0] = want_mode;
      set_register(REG_FRAME_MODE, data);
      data = 8'($urandom);
      data[4:0] = want_hdr;
      set_register(REG_HEADER_BITS, data);
      if ($urandom_range(0, 3) == 0) set_register(REG_SPARE, 8'($urandom));
      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          send_command_frame(1'b0);
        end else if (pick < 77) begin
          send_command_frame(1'b1);
        end else if (pick < 92) begin
          n = $urandom_range(1, 4);
          repeat (n) send_item(OP_BYTE, 8'($urandom), $urandom_range(0, 9) == 0);
        end else begin
          send_item(OP_CLEAR, 8'($urandom), 1'($urandom));
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_checksum_defaults();
    test_invert_frame();
    test_mode_switch_window();
    test_output_backpressure();
    test_random_traffic();
    wait_for_idle();
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
